@@ hdl/tdd_pkg.sv @@
// Shared types, constants and helpers for the track distance decimator.
`default_nettype none

package tdd_pkg;

	localparam int ID_COUNT_DEF = 4096;
	localparam int ID_W         = 12;
	localparam int POS_W        = 32;
	localparam int SEG_W        = 31;
	localparam int PATH_W       = 12;
	localparam int CNT_W        = 13;
	localparam int KIND_W       = 2;
	localparam int S_TDATA_W    = 112;
	localparam int M_TDATA_W    = 120;
	localparam int M_TUSER_W    = 3;
	localparam int DATA_W       = PATH_W + 3 * POS_W;
	localparam int SQ_W         = 2 * POS_W;
	localparam int ACC_W        = SQ_W + 2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DEATH  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		VK_SPAWN = 2'd0,
		VK_STEP  = 2'd1,
		VK_DEATH = 2'd2
	} vkind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_SQM,
		ST_CMP
	} state_t;

	typedef enum logic [1:0] {
		MS_DX,
		MS_DY,
		MS_DZ,
		MS_SEG
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic     in_load;
		logic     rd_en;
		logic     diff_load;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     clr_en;
		logic     out_load;
		logic     out_echo;
		logic     out_emit;
		vkind_t   out_kind;
		logic     out_closed;
		logic     path_new;
		logic     data_we;
		logic     flag_we;
		logic     flag_closed;
	} dp_ctl_t;

	typedef struct packed {
		logic cmd;
		logic in_range;
		logic seen;
		logic closed;
		logic seg_zero;
		logic pos_same;
		logic far;
		logic out_free;
		logic clr_last;
	} dp_sts_t;

	function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic signed [POS_W:0] d;
		logic signed [POS_W:0] m;
		d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
		m = -d;
		return d[POS_W] ? m[POS_W-1:0] : d[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/track_distance_decimator.sv @@
// Top level of the per-particle track distance decimator.
//
//  Channel   Direction  Handshake            Contents
//  cfg       in         cfg_we               segment length threshold, Q16.16
//  s_*       in         s_tvalid / s_tready  command, particle id, position
//  m_*       out        m_tvalid / m_tready  vertex flags, path, id, position
//
// An item passes through the idle and lookup states; when a sample of an open path is
// tested against a nonzero threshold, it also passes the squaring and compare states, where
// one 32x32 squarer handles dx, dy, dz and the threshold. After reset the flag table is
// cleared entry by entry; no transaction is taken on the input until then. A result waits
// in the output register; a stalled output holds the next item in its write-back step.
`default_nettype none

module track_distance_decimator
	import tdd_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [SEG_W-1:0]     cfg_wdata,   // segment length threshold
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,     // particle id, pos_x/y/z, zero pad
	input  wire logic                 s_tuser,     // command
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,     // path_number, vertex_id, vertex_x/y/z
	output logic [M_TUSER_W-1:0]      m_tuser,     // emit_vertex, vertex_kind
	output logic                      m_tlast      // path_closed
);

	dp_ctl_t ctl;
	dp_sts_t sts;

	tdd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	tdd_datapath #(
		.ID_COUNT(ID_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ hdl/tdd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/tdd_datapath.sv @@
// Datapath: track tables, distance arithmetic, path counter and result register.
`default_nettype none

module tdd_datapath
	import tdd_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF,
	localparam int IDX_W = $clog2(ID_COUNT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_ctl_t              ctl,
	output dp_sts_t                   sts,
	input  wire logic                 cfg_we,
	input  wire logic [SEG_W-1:0]     cfg_wdata,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic [M_TUSER_W-1:0]      m_tuser,
	output logic                      m_tlast
);

	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [POS_W-1:0]  x_q, y_q, z_q;
	logic [SEG_W-1:0]  seg_q;
	logic [CNT_W-1:0]  paths_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [POS_W-1:0]  dx_q, dy_q, dz_q;
	logic [SQ_W-1:0]   prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [POS_W-1:0]  mul_a;
	logic [SQ_W-1:0]   sq;

	logic [IDX_W+ID_W-1:0] rd_ext, wr_ext;
	logic [IDX_W-1:0]  rd_idx, id_idx;
	logic [1:0]        flag_rdata, flag_wdata;
	logic [IDX_W-1:0]  flag_waddr;
	logic [DATA_W-1:0] data_rdata, data_wdata;
	logic [PATH_W-1:0] rd_path, wr_path, res_path;
	logic [POS_W-1:0]  rd_x, rd_y, rd_z;

	logic              out_valid_q;
	logic              out_emit_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_closed_q;
	logic [PATH_W-1:0] out_path_q;
	logic [ID_W-1:0]   out_id_q;
	logic [POS_W-1:0]  out_x_q, out_y_q, out_z_q;

	assign rd_ext = (IDX_W + ID_W)'(s_tdata[ID_W-1:0]);
	assign rd_idx = rd_ext[IDX_W-1:0];
	assign wr_ext = (IDX_W + ID_W)'(id_q);
	assign id_idx = wr_ext[IDX_W-1:0];

	assign flag_waddr = ctl.clr_en ? clr_cnt_q : id_idx;
	assign flag_wdata = ctl.clr_en ? 2'b00 : {1'b1, ctl.flag_closed};

	tdd_ram #(
		.WIDTH(2),
		.DEPTH(ID_COUNT)
	) u_flag_ram (
		.clk  (clk),
		.we   (ctl.clr_en | ctl.flag_we),
		.waddr(flag_waddr),
		.wdata(flag_wdata),
		.re   (ctl.rd_en),
		.raddr(rd_idx),
		.rdata(flag_rdata)
	);

	assign rd_x    = data_rdata[POS_W-1:0];
	assign rd_y    = data_rdata[2*POS_W-1:POS_W];
	assign rd_z    = data_rdata[3*POS_W-1:2*POS_W];
	assign rd_path = data_rdata[DATA_W-1:3*POS_W];
	assign wr_path = ctl.path_new ? paths_q[PATH_W-1:0] : rd_path;
	assign data_wdata = {wr_path, z_q, y_q, x_q};

	tdd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(ID_COUNT)
	) u_data_ram (
		.clk  (clk),
		.we   (ctl.data_we),
		.waddr(id_idx),
		.wdata(data_wdata),
		.re   (ctl.rd_en),
		.raddr(rd_idx),
		.rdata(data_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			cmd_q <= s_tuser;
			id_q  <= s_tdata[ID_W-1:0];
			x_q   <= s_tdata[ID_W+POS_W-1:ID_W];
			y_q   <= s_tdata[ID_W+2*POS_W-1:ID_W+POS_W];
			z_q   <= s_tdata[ID_W+3*POS_W-1:ID_W+2*POS_W];
		end
		if (ctl.diff_load) begin
			dx_q <= absdiff(x_q, rd_x);
			dy_q <= absdiff(y_q, rd_y);
			dz_q <= absdiff(z_q, rd_z);
		end
		if (ctl.mul_en) begin
			prod_q <= sq;
		end
		case (ctl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
	end

	always_comb begin
		unique case (ctl.mul_sel)
			MS_DX:   mul_a = dx_q;
			MS_DY:   mul_a = dy_q;
			MS_DZ:   mul_a = dz_q;
			MS_SEG:  mul_a = {1'b0, seg_q};
			default: mul_a = dx_q;
		endcase
	end

	assign sq = SQ_W'(mul_a) * SQ_W'(mul_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= '0;
			paths_q   <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				seg_q <= cfg_wdata;
			end
			if (ctl.out_load && ctl.path_new) begin
				paths_q <= paths_q + CNT_W'(1);
			end
			if (ctl.clr_en) begin
				clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			end
		end
	end

	assign res_path = ctl.path_new ? paths_q[PATH_W-1:0] :
		(ctl.out_echo ? rd_path : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_emit_q   <= ctl.out_emit;
			out_kind_q   <= ctl.out_kind;
			out_closed_q <= ctl.out_closed;
			out_path_q   <= res_path;
			out_id_q     <= ctl.out_echo ? id_q : '0;
			out_x_q      <= ctl.out_emit ? x_q : '0;
			out_y_q      <= ctl.out_emit ? y_q : '0;
			out_z_q      <= ctl.out_emit ? z_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_z_q, out_y_q, out_x_q, out_id_q, out_path_q};
	assign m_tuser  = {out_kind_q, out_emit_q};
	assign m_tlast  = out_closed_q;

	assign sts.cmd      = cmd_q;
	assign sts.in_range = 32'(id_q) < 32'(ID_COUNT);
	assign sts.seen     = flag_rdata[1];
	assign sts.closed   = flag_rdata[0];
	assign sts.seg_zero = (seg_q == '0);
	assign sts.pos_same = (x_q == rd_x) && (y_q == rd_y) && (z_q == rd_z);
	assign sts.far      = acc_q >= ACC_W'(prod_q);
	assign sts.out_free = !out_valid_q || m_tready;
	assign sts.clr_last = (clr_cnt_q == IDX_W'(ID_COUNT - 1));

endmodule

`default_nettype wire

@@ hdl/tdd_ctrl.sv @@
// Controller: sequences table clearing, lookup, distance steps and write-back.
`default_nettype none

module tdd_ctrl
	import tdd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire dp_sts_t sts,
	output dp_ctl_t      ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.mul_sel  = MS_DX;
		ctl.acc_op   = ACC_HOLD;
		ctl.out_kind = VK_SPAWN;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				ctl.in_load = s_tvalid;
				ctl.rd_en   = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				ctl.diff_load = 1'b1;
				if (sts.in_range && sts.cmd == CMD_SAMPLE && sts.seen && !sts.closed &&
						!sts.seg_zero) begin
					state_d = ST_SQX;
				end else if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
					if (sts.in_range) begin
						if (sts.cmd == CMD_SAMPLE) begin
							ctl.out_echo = 1'b1;
							if (!sts.seen) begin
								ctl.out_emit = 1'b1;
								ctl.path_new = 1'b1;
								ctl.data_we  = 1'b1;
								ctl.flag_we  = 1'b1;
							end
						end else if (sts.seen) begin
							ctl.out_echo = 1'b1;
							if (!sts.closed) begin
								ctl.out_emit    = !sts.pos_same;
								ctl.out_kind    = sts.pos_same ? VK_SPAWN : VK_DEATH;
								ctl.out_closed  = 1'b1;
								ctl.flag_we     = 1'b1;
								ctl.flag_closed = 1'b1;
							end
						end
					end
				end
			end
			ST_SQX: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DX;
				state_d     = ST_SQY;
			end
			ST_SQY: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DY;
				ctl.acc_op  = ACC_LOAD;
				state_d     = ST_SQZ;
			end
			ST_SQZ: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_DZ;
				ctl.acc_op  = ACC_ADD;
				state_d     = ST_SQM;
			end
			ST_SQM: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_SEG;
				ctl.acc_op  = ACC_ADD;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_echo = 1'b1;
					state_d      = ST_IDLE;
					if (sts.far) begin
						ctl.out_emit = 1'b1;
						ctl.out_kind = VK_STEP;
						ctl.data_we  = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/tdd_checker.sv @@
// Port-level checker for the track distance decimator and its bind.
`default_nettype none

module tdd_checker
	import tdd_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser,
	input wire logic                 m_tlast
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Items are processed one at a time: no transaction directly after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in back-to-back cycles");

	// Without a vertex, the kind is spawn and the position is zero.
	a_no_vertex_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			m_tuser[2:1] == VK_SPAWN && m_tdata[M_TDATA_W-1:2*ID_W] == '0)
		else $error("payload present without a vertex");

	// A death vertex always closes the path, and an emitted vertex of another kind never closes it.
	a_death_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tuser[2:1] == VK_DEATH) == m_tlast)
		else $error("death vertex and path closing disagree");

endmodule

bind track_distance_decimator tdd_checker u_tdd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

`default_nettype wire

@@ verif/tb_track_distance_decimator.sv @@
// Self-checking testbench for the track distance decimator, with directed and random tracks.
`default_nettype none

module tb_track_distance_decimator;
	import tdd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1_000_000;
	localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

	typedef struct {
		logic             cmd;
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} track_item_t;

	typedef struct {
		logic              emit;
		vkind_t            kind;
		logic              closed;
		logic [PATH_W-1:0] path;
		logic [ID_W-1:0]   id;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
	} vertex_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [SEG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	track_item_t feed_q[$];
	vertex_t     vertex_q[$];
	track_item_t cur_item;
	vertex_t     got_vertex;
	vertex_t     want_vertex;
	logic        fire;
	int          src_gap = 0;
	int          sink_wait = 0;
	bit          calm = 0;
	int          errors = 0;
	int          cycles = 0;

	// Expected state of the track table.
	bit                seen_tab[ID_COUNT_DEF];
	bit                closed_tab[ID_COUNT_DEF];
	logic [POS_W-1:0]  rec_x[ID_COUNT_DEF];
	logic [POS_W-1:0]  rec_y[ID_COUNT_DEF];
	logic [POS_W-1:0]  rec_z[ID_COUNT_DEF];
	logic [PATH_W-1:0] path_of[ID_COUNT_DEF];
	logic [CNT_W-1:0]  path_count = '0;
	logic [SEG_W-1:0]  seg_cfg = '0;

	track_distance_decimator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		logic signed [POS_W:0] d;
		logic signed [POS_W:0] n;
		d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
		n = -d;
		return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
	endfunction

	// The squared distance is kept at full width; anything past 64 bits is far enough.
	function automatic bit far_from_last(input track_item_t it);
		logic [POS_W-1:0] dx, dy, dz;
		logic [SQ_W+1:0]  sum;
		logic [SQ_W-1:0]  lim;
		dx = span(it.x, rec_x[it.id]);
		dy = span(it.y, rec_y[it.id]);
		dz = span(it.z, rec_z[it.id]);
		sum = {34'd0, dx} * {34'd0, dx} + {34'd0, dy} * {34'd0, dy}
			+ {34'd0, dz} * {34'd0, dz};
		lim = {33'd0, seg_cfg} * {33'd0, seg_cfg};
		return (sum[SQ_W+1:SQ_W] != 2'd0) || (sum[SQ_W-1:0] >= lim);
	endfunction

	function automatic void decimate(input track_item_t it);
		vertex_t v;
		v = '{emit: 1'b0, kind: VK_SPAWN, closed: 1'b0, path: '0, id: '0,
			x: '0, y: '0, z: '0};
		if (it.cmd == CMD_SAMPLE || seen_tab[it.id]) begin
			if (it.cmd == CMD_SAMPLE) begin
				if (!seen_tab[it.id]) begin
					seen_tab[it.id] = 1;
					closed_tab[it.id] = 0;
					path_of[it.id] = path_count[PATH_W-1:0];
					path_count = path_count + CNT_W'(1);
					v.emit = 1'b1;
					v.kind = VK_SPAWN;
				end else if (!closed_tab[it.id] && seg_cfg != 0 && far_from_last(it)) begin
					v.emit = 1'b1;
					v.kind = VK_STEP;
				end
				if (v.emit) begin
					rec_x[it.id] = it.x;
					rec_y[it.id] = it.y;
					rec_z[it.id] = it.z;
				end
			end else if (!closed_tab[it.id]) begin
				if (it.x != rec_x[it.id] || it.y != rec_y[it.id] || it.z != rec_z[it.id]) begin
					v.emit = 1'b1;
					v.kind = VK_DEATH;
				end
				closed_tab[it.id] = 1;
				v.closed = 1'b1;
			end
			v.path = path_of[it.id];
			v.id = it.id;
			if (v.emit) begin
				v.x = it.x;
				v.y = it.y;
				v.z = it.z;
			end
		end
		vertex_q = {vertex_q, v};
	endfunction

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic void push(input logic cmd, input logic [ID_W-1:0] id,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		track_item_t it;
		it.cmd = cmd;
		it.id = id;
		it.x = x;
		it.y = y;
		it.z = z;
		feed_q = {feed_q, it};
	endfunction

	// Moves a coordinate by up to reach, now and then jumping anywhere.
	function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] v,
		input logic [POS_W-1:0] reach);
		logic [POS_W-1:0] d;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom;
		d = (r < 4) ? '0 : $urandom_range(0, reach);
		return $urandom_range(0, 1) ? v + d : v - d;
	endfunction

	task automatic queue_tracks(input int n);
		bit               live[12];
		logic [ID_W-1:0]  sid[12];
		logic [POS_W-1:0] cx[12], cy[12], cz[12];
		int               life[12];
		int               k;
		logic [POS_W-1:0] reach;
		for (int i = 0; i < 12; i++)
			live[i] = 0;
		reach = (seg_cfg == 0) ? (32'd1 << $urandom_range(0, 24)) : {1'b0, seg_cfg};
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 11);
			if ($urandom_range(0, 9) == 0) begin
				push(1'($urandom_range(0, 1)), 12'($urandom), $urandom, $urandom, $urandom);
			end else if (!live[k]) begin
				sid[k] = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 31)) : 12'($urandom);
				cx[k] = $urandom;
				cy[k] = $urandom;
				cz[k] = $urandom;
				life[k] = $urandom_range(2, 25);
				live[k] = 1;
				push(CMD_SAMPLE, sid[k], cx[k], cy[k], cz[k]);
			end else if (life[k] == 0) begin
				if ($urandom_range(0, 2) == 0)
					push(CMD_DEATH, sid[k], cx[k], cy[k], cz[k]);
				else
					push(CMD_DEATH, sid[k], nudge(cx[k], reach), nudge(cy[k], reach),
						nudge(cz[k], reach));
				live[k] = 0;
			end else begin
				cx[k] = nudge(cx[k], reach);
				cy[k] = nudge(cy[k], reach);
				cz[k] = nudge(cz[k], reach);
				life[k]--;
				push(CMD_SAMPLE, sid[k], cx[k], cy[k], cz[k]);
			end
		end
	endtask

	task automatic set_seg_len(input logic [SEG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		seg_cfg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (feed_q.size() != 0 || s_tvalid || vertex_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			fire = s_tvalid && s_tready;
			if (fire)
				decimate(cur_item);
			if (!s_tvalid || fire) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (feed_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					cur_item = feed_q.pop_front();
					s_tdata <= {4'b0, cur_item.z, cur_item.y, cur_item.x, cur_item.id};
					s_tuser <= cur_item.cmd;
					s_tvalid <= 1'b1;
					src_gap = idle_len();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_vertex.path = m_tdata[11:0];
				got_vertex.id = m_tdata[23:12];
				got_vertex.x = m_tdata[55:24];
				got_vertex.y = m_tdata[87:56];
				got_vertex.z = m_tdata[119:88];
				got_vertex.emit = m_tuser[0];
				got_vertex.kind = vkind_t'(m_tuser[2:1]);
				got_vertex.closed = m_tlast;
				if (vertex_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected vertex transaction: id=%0d path=%0d", got_vertex.id,
							got_vertex.path);
				end else begin
					want_vertex = vertex_q.pop_front();
					if (got_vertex.emit !== want_vertex.emit || got_vertex.kind !== want_vertex.kind
						|| got_vertex.closed !== want_vertex.closed
						|| got_vertex.path !== want_vertex.path || got_vertex.id !== want_vertex.id
						|| got_vertex.x !== want_vertex.x || got_vertex.y !== want_vertex.y
						|| got_vertex.z !== want_vertex.z) begin
						errors++;
						if (errors <= 10) begin
							$display("Mismatch exp: emit=%0b kind=%0d closed=%0b path=%0d id=%0d xyz=%h %h %h",
								want_vertex.emit, want_vertex.kind, want_vertex.closed, want_vertex.path,
								want_vertex.id, want_vertex.x, want_vertex.y, want_vertex.z);
							$display("         got: emit=%0b kind=%0d closed=%0b path=%0d id=%0d xyz=%h %h %h",
								got_vertex.emit, got_vertex.kind, got_vertex.closed, got_vertex.path,
								got_vertex.id, got_vertex.x, got_vertex.y, got_vertex.z);
						end
					end
				end
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				sink_wait = idle_len();
				m_tready <= (sink_wait == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [SEG_W-1:0] seg_plan[7];
		for (int i = 0; i < ID_COUNT_DEF; i++) begin
			seen_tab[i] = 0;
			closed_tab[i] = 0;
			rec_x[i] = '0;
			rec_y[i] = '0;
			rec_z[i] = '0;
			path_of[i] = '0;
		end
		seg_plan = '{31'd0, 31'h0001_0000, 31'd1, 31'h7FFF_FFFF,
			31'($urandom_range(2, 1 << 20)), 31'($urandom), 31'h0000_0400};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Largest threshold: exact boundary, carry past 64 bits, deaths in every state.
		set_seg_len(31'h7FFF_FFFF);
		push(CMD_SAMPLE, 12'd0, 32'd0, 32'd0, 32'd0);
		push(CMD_SAMPLE, 12'd0, POS_MAX, POS_MAX, POS_MAX);
		push(CMD_SAMPLE, 12'd0, POS_MIN, POS_MIN, POS_MIN);
		push(CMD_SAMPLE, 12'd0, POS_MIN, POS_MIN, POS_MIN + 1);
		push(CMD_DEATH, 12'd0, POS_MIN, POS_MIN, POS_MIN);
		push(CMD_SAMPLE, 12'd0, 32'd1, 32'd2, 32'd3);
		push(CMD_DEATH, 12'd0, 32'd5, 32'd5, 32'd5);
		push(CMD_DEATH, 12'd4095, 32'd7, 32'd7, 32'd7);
		push(CMD_SAMPLE, 12'd4095, POS_MAX, POS_MIN, 32'd0);
		push(CMD_DEATH, 12'd4095, POS_MAX, POS_MIN, 32'd1);
		push(CMD_SAMPLE, 12'd1, 32'd0, 32'd0, 32'd0);
		push(CMD_SAMPLE, 12'd1, POS_MAX, 32'd0, 32'd0);
		push(CMD_SAMPLE, 12'd1, 32'd1, 32'd0, 32'd0);
		push(CMD_SAMPLE, 12'd1, 32'd1, POS_MIN, 32'd0);
		push(CMD_DEATH, 12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Smallest nonzero threshold: a one-LSB move is enough.
		set_seg_len(31'd1);
		push(CMD_SAMPLE, 12'd2, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000);
		push(CMD_SAMPLE, 12'd2, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000);
		push(CMD_SAMPLE, 12'd2, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0001);
		push(CMD_DEATH, 12'd2, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0001);
		push(CMD_SAMPLE, 12'd2, 32'h0, 32'h0, 32'h0);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			calm = (ph % 3 == 1);
			set_seg_len(seg_plan[ph]);
			queue_tracks(250);
			drain();
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/tdd_pkg.sv
hdl/tdd_ram.sv
hdl/tdd_datapath.sv
hdl/tdd_ctrl.sv
hdl/track_distance_decimator.sv
hdl/tdd_checker.sv
verif/tb_track_distance_decimator.sv
